### design/sivd_pkg.sv
// Shared constants and types for the signed varint decoder.
package sivd_pkg;

	localparam int DEF_VALUE_BITS    = 32;
	localparam int DEF_POSITION_BITS = 24;
	localparam int DEF_COUNT_BITS    = 16;

	localparam int SHIFT_BITS = 6;
	localparam logic [SHIFT_BITS-1:0] SHIFT_INIT = 6'd6;
	localparam logic [SHIFT_BITS:0]   SHIFT_STEP = 7'd7;
	localparam logic [SHIFT_BITS:0]   SHIFT_CAP  = 7'd63;

	localparam logic [7:0] HEAD_MAG_MASK = 8'h3F;
	localparam logic [7:0] SIGN_MASK     = 8'h40;
	localparam logic [7:0] CONT_MASK     = 8'h80;
	localparam logic [7:0] TAIL_MAG_MASK = 8'h7F;

	localparam int CFG_INDEX_BITS = 2;
	localparam logic [CFG_INDEX_BITS-1:0] CFG_START_OFFSET = 2'd0;
	localparam logic [CFG_INDEX_BITS-1:0] CFG_VALUE_COUNT  = 2'd1;

	localparam logic [1:0] STATUS_OK    = 2'd0;
	localparam logic [1:0] STATUS_SHORT = 2'd1;
	localparam logic [1:0] STATUS_SAT   = 2'd2;

	typedef struct packed {
		logic [SHIFT_BITS-1:0] bit_shift;
		logic                  negative;
		logic                  mid_value;
		logic                  saturated;
		logic                  finished;
	} sivd_flags_t;

	typedef struct packed {
		logic       valid;
		logic [1:0] status;
		logic       last;
	} sivd_res_t;

endpackage

### design/signed_varint_decoder.sv
// Signed varint decoder top level: input stage, decoder state and result register.
// Each byte is held in the input stage; its result is then registered for the output.
// Throughput: one byte per cycle unless out_stall holds a result; one state update per byte.
// Reset clears configuration, decoder state and both valid flags.
module signed_varint_decoder #(
	parameter int VALUE_BITS    = sivd_pkg::DEF_VALUE_BITS,
	parameter int POSITION_BITS = sivd_pkg::DEF_POSITION_BITS,
	parameter int COUNT_BITS    = sivd_pkg::DEF_COUNT_BITS
) (
	input  logic                                   clk,
	input  logic                                   arst_n,
	input  logic                                   cfg_valid,
	output logic                                   cfg_ready,
	input  logic [sivd_pkg::CFG_INDEX_BITS-1:0]    cfg_index,
	input  logic [((POSITION_BITS > COUNT_BITS) ? POSITION_BITS : COUNT_BITS)-1:0] cfg_data,
	input  logic                                   in_valid,
	output logic                                   in_stall,
	input  logic [7:0]                             data_byte,
	input  logic                                   buffer_first,
	input  logic                                   buffer_last,
	output logic                                   out_valid,
	input  logic                                   out_stall,
	output logic signed [VALUE_BITS-1:0]           value,
	output logic [POSITION_BITS-1:0]               next_position,
	output logic [1:0]                             status,
	output logic                                   last_value
);
	import sivd_pkg::*;

	logic [POSITION_BITS-1:0]     start_offset_q;
	logic [COUNT_BITS-1:0]        value_count_q;

	logic                         valid_s1;
	logic [7:0]                   data_byte_s1;
	logic                         first_s1;
	logic                         last_s1;

	logic [VALUE_BITS-2:0]        mag_q;
	sivd_flags_t                  flags_q;
	logic [POSITION_BITS-1:0]     pos_q;
	logic [COUNT_BITS-1:0]        done_q;

	logic [VALUE_BITS-2:0]        mag_d;
	sivd_flags_t                  flags_d;
	logic [POSITION_BITS-1:0]     pos_d;
	logic [COUNT_BITS-1:0]        done_d;
	sivd_res_t                    res;
	logic signed [VALUE_BITS-1:0] res_value;
	logic [POSITION_BITS-1:0]     res_position;

	logic                         out_valid_q;
	logic                         advance;
	logic                         in_accept;

	assign cfg_ready = 1'b1;
	assign advance   = valid_s1 && (!out_valid_q || !out_stall);
	assign in_stall  = valid_s1 && !advance;
	assign in_accept = in_valid && !in_stall;
	assign out_valid = out_valid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			start_offset_q <= '0;
			value_count_q  <= '0;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				CFG_START_OFFSET: start_offset_q <= cfg_data[POSITION_BITS-1:0];
				CFG_VALUE_COUNT:  value_count_q  <= cfg_data[COUNT_BITS-1:0];
				default:          ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_accept) begin
			valid_s1 <= 1'b1;
		end else if (advance) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_accept) begin
			data_byte_s1 <= data_byte;
			first_s1     <= buffer_first;
			last_s1      <= buffer_last;
		end
	end

	sivd_step #(
		.VALUE_BITS   (VALUE_BITS),
		.POSITION_BITS(POSITION_BITS),
		.COUNT_BITS   (COUNT_BITS)
	) u_step (
		.start_offset(start_offset_q),
		.value_count (value_count_q),
		.data_byte   (data_byte_s1),
		.buffer_first(first_s1),
		.buffer_last (last_s1),
		.mag         (mag_q),
		.flags       (flags_q),
		.pos         (pos_q),
		.done        (done_q),
		.mag_d       (mag_d),
		.flags_d     (flags_d),
		.pos_d       (pos_d),
		.done_d      (done_d),
		.res         (res),
		.res_value   (res_value),
		.res_position(res_position)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mag_q             <= '0;
			flags_q.bit_shift <= SHIFT_INIT;
			flags_q.negative  <= 1'b0;
			flags_q.mid_value <= 1'b0;
			flags_q.saturated <= 1'b0;
			flags_q.finished  <= 1'b0;
			pos_q             <= '0;
			done_q            <= '0;
		end else if (advance) begin
			mag_q   <= mag_d;
			flags_q <= flags_d;
			pos_q   <= pos_d;
			done_q  <= done_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance && res.valid) begin
			out_valid_q <= 1'b1;
		end else if (out_valid_q && !out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && res.valid) begin
			value         <= res_value;
			next_position <= res_position;
			status        <= res.status;
			last_value    <= res.last;
		end
	end

endmodule

### design/sivd_step.sv
// Per-byte decode logic: next decoder state and the result of one item.
module sivd_step #(
	parameter int VALUE_BITS    = sivd_pkg::DEF_VALUE_BITS,
	parameter int POSITION_BITS = sivd_pkg::DEF_POSITION_BITS,
	parameter int COUNT_BITS    = sivd_pkg::DEF_COUNT_BITS
) (
	input  logic [POSITION_BITS-1:0]     start_offset,
	input  logic [COUNT_BITS-1:0]        value_count,
	input  logic [7:0]                   data_byte,
	input  logic                         buffer_first,
	input  logic                         buffer_last,
	input  logic [VALUE_BITS-2:0]        mag,
	input  sivd_pkg::sivd_flags_t        flags,
	input  logic [POSITION_BITS-1:0]     pos,
	input  logic [COUNT_BITS-1:0]        done,
	output logic [VALUE_BITS-2:0]        mag_d,
	output sivd_pkg::sivd_flags_t        flags_d,
	output logic [POSITION_BITS-1:0]     pos_d,
	output logic [COUNT_BITS-1:0]        done_d,
	output sivd_pkg::sivd_res_t          res,
	output logic signed [VALUE_BITS-1:0] res_value,
	output logic [POSITION_BITS-1:0]     res_position
);
	import sivd_pkg::*;

	localparam int MAGW = VALUE_BITS - 1;
	localparam logic [MAGW-1:0] MAG_MAX = {MAGW{1'b1}};

	logic [6:0]            add_bits;
	logic [MAGW+6:0]       ext;
	logic                  shift_big;
	logic                  over;
	logic [MAGW:0]         sum;
	logic                  sat_new;
	logic [MAGW-1:0]       mag_add;
	logic [SHIFT_BITS:0]   shift_sum;
	logic [SHIFT_BITS-1:0] shift_add;

	assign add_bits  = data_byte[6:0] & TAIL_MAG_MASK[6:0];
	assign ext       = (MAGW + 7)'(add_bits) << flags.bit_shift;
	assign shift_big = {1'b0, flags.bit_shift} >= (SHIFT_BITS + 1)'(MAGW);
	assign over      = |ext[MAGW+6:MAGW];
	assign sum       = {1'b0, mag} + {1'b0, ext[MAGW-1:0]};
	assign sat_new   = flags.saturated ||
		((add_bits != 7'd0) && (shift_big || over || sum[MAGW]));
	assign mag_add   = sat_new ? MAG_MAX : ((add_bits == 7'd0) ? mag : sum[MAGW-1:0]);
	assign shift_sum = {1'b0, flags.bit_shift} + SHIFT_STEP;
	assign shift_add = (shift_sum > SHIFT_CAP) ? SHIFT_CAP[SHIFT_BITS-1:0]
		: shift_sum[SHIFT_BITS-1:0];

	always_comb begin
		logic             active;
		logic             complete;
		logic [MAGW:0]    mag_ext;
		mag_d        = mag;
		flags_d      = flags;
		pos_d        = pos;
		done_d       = done;
		res          = '0;
		res_value    = '0;
		res_position = '0;
		complete     = 1'b0;
		mag_ext      = '0;
		if (buffer_first) begin
			mag_d             = '0;
			flags_d.bit_shift = SHIFT_INIT;
			flags_d.negative  = 1'b0;
			flags_d.mid_value = 1'b0;
			flags_d.saturated = 1'b0;
			flags_d.finished  = 1'b0;
			pos_d             = start_offset;
			done_d            = '0;
		end
		active = !flags_d.finished && (done_d < value_count);
		if (active) begin
			pos_d        = pos_d + POSITION_BITS'(1);
			res_position = pos_d;
			if (!flags_d.mid_value) begin
				mag_d             = MAGW'(data_byte & HEAD_MAG_MASK);
				flags_d.bit_shift = SHIFT_INIT;
				flags_d.saturated = 1'b0;
				flags_d.negative  = (data_byte & SIGN_MASK) != 8'd0;
				if ((data_byte & CONT_MASK) != 8'd0) begin
					flags_d.mid_value = 1'b1;
				end else begin
					complete = 1'b1;
				end
			end else begin
				mag_d             = mag_add;
				flags_d.saturated = sat_new;
				flags_d.bit_shift = shift_add;
				if ((data_byte & CONT_MASK) == 8'd0) begin
					flags_d.mid_value = 1'b0;
					complete          = 1'b1;
				end
			end
			if (complete) begin
				done_d = done_d + COUNT_BITS'(1);
			end
			if (buffer_last && (done_d < value_count)) begin
				res.valid        = 1'b1;
				res.status       = STATUS_SHORT;
				res.last         = 1'b1;
				flags_d.finished = 1'b1;
			end else if (complete) begin
				mag_ext    = {1'b0, mag_d};
				res_value  = flags_d.negative ? -$signed(mag_ext) : $signed(mag_ext);
				res.valid  = 1'b1;
				res.status = flags_d.saturated ? STATUS_SAT : STATUS_OK;
				res.last   = done_d >= value_count;
				flags_d.finished = done_d >= value_count;
			end
			if (res.valid) begin
				mag_d             = '0;
				flags_d.bit_shift = SHIFT_INIT;
				flags_d.negative  = 1'b0;
				flags_d.mid_value = 1'b0;
				flags_d.saturated = 1'b0;
			end
		end
	end

endmodule

### test/tb_top.sv
// Self-checking testbench for the signed varint decoder, with a scoreboard and random traffic.
module tb_top;
	timeunit 1ns;
	timeprecision 1ps;

	import sivd_pkg::*;

	localparam int VB = DEF_VALUE_BITS;
	localparam int PB = DEF_POSITION_BITS;
	localparam int CB = DEF_COUNT_BITS;
	localparam int CFG_BITS = (PB > CB) ? PB : CB;
	localparam int RANDOM_ITEMS = 1900;

	typedef struct {
		logic signed [VB-1:0] value;
		logic [PB-1:0]        position;
		logic [1:0]           status;
		logic                 last;
	} decoded_t;

	class varint_scoreboard;
		localparam logic [63:0] MAG_MAX = (64'd1 << (VB - 1)) - 64'd1;

		decoded_t      pending_values[$];
		int            mismatches;
		logic [PB-1:0] start_off;
		logic [CB-1:0] count_limit;
		logic [VB-2:0] mag;
		logic [5:0]    shift;
		logic          neg;
		logic          in_value;
		logic          sat;
		logic          finished;
		logic [PB-1:0] pos;
		logic [CB-1:0] done_cnt;

		function new();
			mismatches = 0;
			start_off = '0;
			count_limit = '0;
			pos = '0;
			done_cnt = '0;
			finished = 1'b0;
			clear_value();
		endfunction

		function void clear_value();
			mag = '0;
			shift = SHIFT_INIT;
			neg = 1'b0;
			in_value = 1'b0;
			sat = 1'b0;
		endfunction

		function void set_register(logic [CFG_INDEX_BITS-1:0] idx, logic [CFG_BITS-1:0] data);
			if (idx == CFG_START_OFFSET)
				start_off = data[PB-1:0];
			else if (idx == CFG_VALUE_COUNT)
				count_limit = data[CB-1:0];
		endfunction

		// Returns 1 when the decoder takes the byte, 0 when it is skipped.
		function bit note_byte(logic [7:0] b, logic first, logic last_in);
			decoded_t      res;
			logic [63:0]   tail_bits;
			logic [63:0]   sum;
			logic [PB-1:0] nxt;
			bit            complete;
			complete = 1'b0;
			if (first) begin
				clear_value();
				pos = start_off;
				done_cnt = '0;
				finished = 1'b0;
			end
			if (finished || done_cnt >= count_limit)
				return 1'b0;
			nxt = pos + 1'b1;
			pos = nxt;
			if (!in_value) begin
				clear_value();
				mag = (VB-1)'(b & HEAD_MAG_MASK);
				neg = |(b & SIGN_MASK);
				if (|(b & CONT_MASK))
					in_value = 1'b1;
				else
					complete = 1'b1;
			end else begin
				tail_bits = 64'(b & TAIL_MAG_MASK);
				if (!sat && tail_bits != 0) begin
					if (shift >= VB - 1 || tail_bits > (MAG_MAX >> shift)) begin
						sat = 1'b1;
					end else begin
						sum = 64'(mag) + (tail_bits << shift);
						if (sum > MAG_MAX)
							sat = 1'b1;
						else
							mag = sum[VB-2:0];
					end
				end
				if (sat)
					mag = '1;
				shift = (int'(shift) + 7 > 63) ? 6'd63 : shift + 6'd7;
				if (!(|(b & CONT_MASK))) begin
					in_value = 1'b0;
					complete = 1'b1;
				end
			end
			if (complete)
				done_cnt = done_cnt + 1'b1;
			if (last_in && done_cnt < count_limit) begin
				res.value = '0;
				res.position = nxt;
				res.status = STATUS_SHORT;
				res.last = 1'b1;
				pending_values.push_back(res);
				finished = 1'b1;
				clear_value();
			end else if (complete) begin
				res.value = neg ? -$signed({1'b0, mag}) : $signed({1'b0, mag});
				res.position = nxt;
				res.status = sat ? STATUS_SAT : STATUS_OK;
				res.last = (done_cnt >= count_limit);
				pending_values.push_back(res);
				if (res.last)
					finished = 1'b1;
				clear_value();
			end
			return 1'b1;
		endfunction

		task report(string msg);
			mismatches++;
			$display("ERROR %0t ns: %s", $time, msg);
		endtask

		task check_value(decoded_t got);
			decoded_t exp_r;
			if (pending_values.size() == 0) begin
				report($sformatf("unexpected value %0d at position 0x%0h status %0d",
					got.value, got.position, got.status));
				return;
			end
			exp_r = pending_values.pop_front();
			if (got.value !== exp_r.value || got.position !== exp_r.position ||
					got.status !== exp_r.status || got.last !== exp_r.last)
				report($sformatf("got value %0d pos 0x%0h status %0d last %0b, expected %0d 0x%0h %0d %0b",
					got.value, got.position, got.status, got.last,
					exp_r.value, exp_r.position, exp_r.status, exp_r.last));
		endtask
	endclass

	logic                      clk = 1'b0;
	logic                      arst_n;
	logic                      cfg_valid;
	logic                      cfg_ready;
	logic [CFG_INDEX_BITS-1:0] cfg_index;
	logic [CFG_BITS-1:0]       cfg_data;
	logic                      in_valid;
	logic                      in_stall;
	logic [7:0]                data_byte;
	logic                      buffer_first;
	logic                      buffer_last;
	logic                      out_valid;
	logic                      out_stall;
	logic signed [VB-1:0]      value;
	logic [PB-1:0]             next_position;
	logic [1:0]                status;
	logic                      last_value;

	varint_scoreboard sb = new();
	logic [7:0]       frame_bytes[$];
	bit               hold_request = 1'b0;
	bit               quiet_tail = 1'b0;
	int               gap_pct = 0;
	int               stall_pct = 0;
	int               consumed = 0;

	signed_varint_decoder dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_valid    (cfg_valid),
		.cfg_ready    (cfg_ready),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data),
		.in_valid     (in_valid),
		.in_stall     (in_stall),
		.data_byte    (data_byte),
		.buffer_first (buffer_first),
		.buffer_last  (buffer_last),
		.out_valid    (out_valid),
		.out_stall    (out_stall),
		.value        (value),
		.next_position(next_position),
		.status       (status),
		.last_value   (last_value)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	task automatic write_register(logic [CFG_INDEX_BITS-1:0] idx, logic [CFG_BITS-1:0] data);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= data;
		@(posedge clk);
		while (!cfg_ready)
			@(posedge clk);
		sb.set_register(idx, data);
		cfg_valid <= 1'b0;
		@(posedge clk);
	endtask

	task automatic send_byte(logic [7:0] b, logic first, logic last_in);
		if (!quiet_tail && $urandom_range(99) < gap_pct) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 11))
				@(posedge clk);
		end
		in_valid <= 1'b1;
		data_byte <= b;
		buffer_first <= first;
		buffer_last <= last_in;
		@(posedge clk);
		while (in_stall)
			@(posedge clk);
		void'(sb.note_byte(b, first, last_in));
		consumed++;
	endtask

	task automatic send_frame(bit mark_first, bit mark_last);
		foreach (frame_bytes[i])
			send_byte(frame_bytes[i], mark_first && i == 0,
				mark_last && i == frame_bytes.size() - 1);
	endtask

	task automatic wait_for_results();
		int waited;
		waited = 0;
		in_valid <= 1'b0;
		while (sb.pending_values.size() != 0 && waited < 4000) begin
			@(posedge clk);
			waited++;
		end
		if (sb.pending_values.size() != 0) begin
			sb.report($sformatf("%0d results never arrived", sb.pending_values.size()));
			sb.pending_values.delete();
		end
		repeat (10)
			@(posedge clk);
	endtask

	// Appends one encoded value: a head byte and up to six tail bytes.
	function automatic void add_value();
		int         pick;
		int         len;
		logic [7:0] b;
		pick = $urandom_range(0, 19);
		if (pick < 8)
			len = 1;
		else if (pick < 13)
			len = 2;
		else if (pick < 16)
			len = 3;
		else if (pick < 18)
			len = 4;
		else
			len = $urandom_range(5, 7);
		for (int i = 0; i < len; i++) begin
			b = 8'($urandom_range(0, 255));
			if (len == 5 && pick == 18 && i > 0)
				b = (i == 4) ? 8'($urandom_range(0, 31)) : TAIL_MAG_MASK;
			b[7] = (i != len - 1);
			frame_bytes.push_back(b);
		end
	endfunction

	task automatic send_random_frame();
		int kind;
		int n;
		kind = $urandom_range(0, 19);
		frame_bytes.delete();
		if (kind < 2) begin
			repeat ($urandom_range(1, 12))
				send_byte(8'($urandom_range(0, 255)), $urandom_range(0, 7) == 0,
					$urandom_range(0, 7) == 0);
			return;
		end
		if (sb.count_limit == 0 || sb.count_limit > 12)
			n = $urandom_range(1, 8);
		else if (kind < 5)
			n = sb.count_limit - 1;
		else if (kind < 7)
			n = sb.count_limit + $urandom_range(1, 3);
		else
			n = sb.count_limit;
		repeat (n)
			add_value();
		if (kind < 5 && $urandom_range(0, 1) == 1) begin
			add_value();
			void'(frame_bytes.pop_back());
		end
		if (frame_bytes.size() == 0)
			frame_bytes.push_back(CONT_MASK);
		send_frame(kind != 19, 1'b1);
	endtask

	task automatic configure_phase();
		logic [CFG_BITS-1:0] off;
		logic [CFG_BITS-1:0] cnt;
		wait_for_results();
		case ($urandom_range(0, 7))
			0, 1: off = '0;
			2, 3: off = CFG_BITS'({PB{1'b1}});
			4: off = CFG_BITS'({PB{1'b1}}) - CFG_BITS'($urandom_range(0, 15));
			default: off = CFG_BITS'($urandom_range(0, 32'hFF_FFFF));
		endcase
		case ($urandom_range(0, 19))
			0: cnt = '0;
			1: cnt = CFG_BITS'({CB{1'b1}});
			2, 3: cnt = CFG_BITS'($urandom_range(7, 40));
			default: cnt = CFG_BITS'($urandom_range(1, 6));
		endcase
		cnt[CFG_BITS-1:CB] = (CFG_BITS - CB)'($urandom);
		if ($urandom_range(0, 3) != 0)
			write_register(CFG_START_OFFSET, off);
		if ($urandom_range(0, 4) != 0)
			write_register(CFG_VALUE_COUNT, cnt);
		case ($urandom_range(0, 2))
			0: gap_pct = 0;
			1: gap_pct = 10;
			default: gap_pct = 30;
		endcase
		case ($urandom_range(0, 2))
			0: stall_pct = 0;
			1: stall_pct = 5;
			default: stall_pct = 20;
		endcase
	endtask

	always @(posedge clk) begin
		decoded_t seen;
		if (arst_n && out_valid && !out_stall) begin
			seen.value = value;
			seen.position = next_position;
			seen.status = status;
			seen.last = last_value;
			sb.check_value(seen);
		end
	end

	initial begin
		out_stall <= 1'b0;
		forever begin
			@(posedge clk);
			if (hold_request) begin
				hold_request = 1'b0;
				out_stall <= 1'b1;
				repeat (120)
					@(posedge clk);
				out_stall <= 1'b0;
			end else if (!quiet_tail && $urandom_range(99) < stall_pct) begin
				out_stall <= 1'b1;
				repeat ($urandom_range(1, 11))
					@(posedge clk);
				out_stall <= 1'b0;
			end
		end
	end

	initial begin
		int  random_start;
		int  phase;
		bit  hold_done;
		arst_n <= 1'b0;
		cfg_valid <= 1'b0;
		cfg_index <= CFG_START_OFFSET;
		cfg_data <= '0;
		in_valid <= 1'b0;
		data_byte <= '0;
		buffer_first <= 1'b0;
		buffer_last <= 1'b0;
		repeat (8)
			@(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Decoding without any buffer start, then a byte after the count is reached.
		write_register(CFG_VALUE_COUNT, CFG_BITS'(3));
		frame_bytes = '{8'h00, 8'h3F, 8'h40, 8'h55};
		send_frame(1'b0, 1'b0);
		wait_for_results();

		// Largest magnitudes, saturation, position wrap and an early end.
		write_register(CFG_START_OFFSET, CFG_BITS'({PB{1'b1}} - 1'b1));
		write_register(CFG_VALUE_COUNT, CFG_BITS'({CB{1'b1}}));
		frame_bytes = '{8'hBF, 8'hFF, 8'hFF, 8'hFF, 8'h0F,
			8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'h0F,
			8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'h10,
			8'h80, 8'h80, 8'h80, 8'h80, 8'h80, 8'h81, 8'h7F};
		send_frame(1'b1, 1'b1);
		wait_for_results();

		// A zero count ignores the buffer; then a buffer that ends exactly at the count.
		write_register(CFG_VALUE_COUNT, CFG_BITS'(0));
		frame_bytes = '{8'h81, 8'h02};
		send_frame(1'b1, 1'b1);
		wait_for_results();
		write_register(CFG_START_OFFSET, CFG_BITS'(5));
		write_register(CFG_VALUE_COUNT, CFG_BITS'(2));
		frame_bytes = '{8'hC1, 8'h00, 8'h2A};
		send_frame(1'b1, 1'b1);

		random_start = consumed;
		phase = 0;
		hold_done = 1'b0;
		while (consumed - random_start < RANDOM_ITEMS) begin
			configure_phase();
			if (!hold_done && phase >= 2 && sb.count_limit != 0) begin
				hold_request = 1'b1;
				hold_done = 1'b1;
			end
			repeat ($urandom_range(3, 12)) begin
				send_random_frame();
				quiet_tail = (consumed - random_start > RANDOM_ITEMS - 250);
			end
			phase++;
		end
		wait_for_results();

		if (sb.mismatches == 0)
			$display("No mismatches found");
		else
			$display("Mismatches found");
		$finish;
	end

	initial begin
		#5_000_000;
		$display("Mismatches found");
		$finish;
	end

endmodule
